// ===== rtl/mwls_pkg.sv =====
// Shared constants, codes and types of the motif window log-odds scanner.
`timescale 1ns / 1ps

package mwls_pkg;

	localparam int DEF_ALPHABET_SIZE = 4;
	localparam int DEF_CONTEXT_ORDER = 2;
	localparam int DEF_MAX_WIDTH     = 32;
	localparam int DEF_MAX_SEQ_LEN   = 65536;
	localparam int DEF_NUM_ROWS      = DEF_ALPHABET_SIZE ** (DEF_CONTEXT_ORDER + 1);

	// Item selector carried in the input tuser.
	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_CODE = 2'd1;
	localparam logic [1:0] FUNC_END  = 2'd2;

	// Result kind carried in the output tuser.
	localparam logic KIND_WINDOW = 1'b0;
	localparam logic KIND_BEST   = 1'b1;

	// Configuration register indexes.
	localparam logic [0:0] REG_CUTOFF      = 1'b0;
	localparam logic [0:0] REG_MOTIF_WIDTH = 1'b1;

	localparam logic [23:0] CUTOFF_RESET = 24'd0;
	localparam logic [5:0]  WIDTH_RESET  = 6'd32;
	localparam logic signed [23:0] SCORE_MIN = 24'sh800000;

	typedef struct packed {
		logic [1:0]  func;
		logic        load_ok;
		logic [31:0] code;
		logic [5:0]  trow;
		logic [4:0]  tcol;
		logic [15:0] tval;
	} item_t;

	typedef struct packed {
		logic               kind;
		logic [15:0]        start_position;
		logic signed [23:0] score;
		logic               above_cutoff;
		logic               no_window;
	} result_t;

endpackage

// ===== rtl/mwls_rowmod.sv =====
// Three-stage pipeline that reduces a k-mer code to its context row.
`timescale 1ns / 1ps

module mwls_rowmod import mwls_pkg::*; #(
	parameter int NUM_ROWS  = DEF_NUM_ROWS,
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int RW        = $clog2(NUM_ROWS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  item_t         in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output item_t         out_item,
	output logic [RW-1:0] out_row
);

	// The code is split into bytes; each byte weight is reduced modulo the row count
	// so that the folded value stays narrow. An exact reciprocal then finishes the job.
	localparam logic [31:0] C1 = 32'((1 << 8) % NUM_ROWS);
	localparam logic [31:0] C2 = 32'((1 << 16) % NUM_ROWS);
	localparam logic [31:0] C3 = 32'((1 << 24) % NUM_ROWS);
	localparam int XW  = $clog2(255 * (1 + 3 * (NUM_ROWS - 1)) + 1);
	localparam int SH  = XW + RW;
	localparam int RCW = XW + 1;
	localparam int QW  = XW + RCW - SH;
	localparam logic [RCW-1:0] RECIP =
		RCW'(((64'd1 << SH) + 64'(NUM_ROWS) - 64'd1) / 64'(NUM_ROWS));

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;
	item_t item_d, item_s1, item_s2, item_s3;
	logic [XW-1:0] x_d, x_s1, x_s2;
	logic [XW+RCW-1:0] prod_s2;
	logic [QW-1:0] q_d;
	logic [XW-1:0] qn_d, r_d;
	logic [RW-1:0] row_s3;
	logic load_ok_d;

	assign rdy3 = !v_s3 || out_ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		x_d = XW'(in_item.code[7:0])
			+ XW'({24'd0, in_item.code[15:8]} * C1)
			+ XW'({24'd0, in_item.code[23:16]} * C2)
			+ XW'({24'd0, in_item.code[31:24]} * C3);
		load_ok_d = (32'(in_item.trow) < 32'(NUM_ROWS)) && (32'(in_item.tcol) < 32'(MAX_WIDTH));
		item_d = in_item;
		item_d.load_ok = load_ok_d;
		q_d  = prod_s2[XW+RCW-1:SH];
		qn_d = XW'(q_d) * XW'(NUM_ROWS);
		r_d  = x_s2 - qn_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			item_s1 <= item_d;
			x_s1 <= x_d;
		end
		if (rdy2) begin
			item_s2 <= item_s1;
			x_s2 <= x_s1;
			prod_s2 <= (XW+RCW)'(x_s1) * (XW+RCW)'(RECIP);
		end
		if (rdy3) begin
			item_s3 <= item_s2;
			if (item_s2.func == FUNC_LOAD) begin
				row_s3 <= RW'(item_s2.trow);
			end else begin
				row_s3 <= RW'(r_d);
			end
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;
	assign out_row   = row_s3;

endmodule

// ===== rtl/mwls_table.sv =====
// Log-odds table memory: one row of all motif columns per word, column write enables.
`timescale 1ns / 1ps

module mwls_table import mwls_pkg::*; #(
	parameter int NUM_ROWS  = DEF_NUM_ROWS,
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int RW        = $clog2(NUM_ROWS),
	parameter int IW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [RW-1:0]               waddr,
	input  logic [IW-1:0]               wcol,
	input  logic [15:0]                 wdata,
	input  logic                        re,
	input  logic [RW-1:0]               raddr,
	output logic [MAX_WIDTH-1:0][15:0]  rdata
);

	logic [MAX_WIDTH-1:0][15:0] mem [NUM_ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr][wcol] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/mwls_accum.sv =====
// Window accumulator shift line, sequence bookkeeping and result register.
`timescale 1ns / 1ps

module mwls_accum import mwls_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_SEQ_LEN = DEF_MAX_SEQ_LEN
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  item_t                      in_item,
	input  logic [MAX_WIDTH-1:0][15:0] rd_data,
	input  logic signed [23:0]         cutoff,
	input  logic [5:0]                 motif_width,
	output logic                       out_valid,
	input  logic                       out_ready,
	output result_t                    out_res
);

	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int IW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int PCW = $clog2(MAX_SEQ_LEN + 1);

	logic v_s4, adv4;
	logic [1:0] func_s4;
	logic signed [23:0] sums_q [MAX_WIDTH];
	logic signed [23:0] tsum [MAX_WIDTH];
	logic [PCW-1:0] count_q, cnt_next, start_d;
	logic signed [23:0] best_q;
	logic seen_q;
	logic out_v_q;
	result_t res_q;
	logic [WW-1:0] w_eff;
	logic [IW-1:0] sel;
	logic signed [23:0] win_sum;
	logic seq_step, win_done, res_go;

	assign adv4 = v_s4 && (!out_v_q || out_ready);
	assign in_ready = !v_s4 || adv4;

	always_comb begin
		if (motif_width == 6'd0) begin
			w_eff = WW'(1);
		end else if (32'(motif_width) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(motif_width);
		end
		// Entry j holds the window that started j positions ago; it takes column j.
		for (int j = 0; j < MAX_WIDTH; j++) begin
			if (WW'(j) < w_eff) begin
				tsum[j] = sums_q[j] + {{8{rd_data[j][15]}}, rd_data[j]};
			end else begin
				tsum[j] = sums_q[j];
			end
		end
		sel      = IW'(w_eff - WW'(1));
		win_sum  = tsum[sel];
		cnt_next = count_q + PCW'(1);
		start_d  = cnt_next - PCW'(w_eff);
		seq_step = adv4 && (func_s4 == FUNC_CODE) && (count_q < PCW'(MAX_SEQ_LEN));
		win_done = cnt_next >= PCW'(w_eff);
		res_go   = (seq_step && win_done) || (adv4 && (func_s4 == FUNC_END));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
			count_q <= '0;
			best_q  <= SCORE_MIN;
			seen_q  <= 1'b0;
			for (int j = 0; j < MAX_WIDTH; j++) begin
				sums_q[j] <= '0;
			end
		end else begin
			if (in_ready) v_s4 <= in_valid;
			if (res_go) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (seq_step) begin
				sums_q[0] <= '0;
				for (int j = 1; j < MAX_WIDTH; j++) begin
					sums_q[j] <= tsum[j-1];
				end
				count_q <= cnt_next;
				if (win_done) begin
					seen_q  <= 1'b1;
					if (win_sum > best_q) best_q <= win_sum;
				end
			end
			if (adv4 && func_s4 == FUNC_END) begin
				count_q <= '0;
				best_q  <= SCORE_MIN;
				seen_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) func_s4 <= in_item.func;
		if (seq_step && win_done) begin
			res_q.kind           <= KIND_WINDOW;
			res_q.start_position <= 16'(start_d);
			res_q.score          <= win_sum;
			res_q.above_cutoff   <= win_sum > cutoff;
			res_q.no_window      <= 1'b0;
		end else if (adv4 && func_s4 == FUNC_END) begin
			res_q.kind           <= KIND_BEST;
			res_q.start_position <= 16'd0;
			res_q.score          <= best_q;
			res_q.above_cutoff   <= seen_q && (best_q > cutoff);
			res_q.no_window      <= !seen_q;
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= PCW'(MAX_SEQ_LEN))
		else $error("position count beyond maximum sequence length");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv4 && func_s4 == FUNC_END) |=> (count_q == '0 && !seen_q && best_q == SCORE_MIN))
		else $error("sequence state not cleared after end of sequence");

	a_seen_count: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (count_q != '0))
		else $error("window seen with empty sequence");

	a_short_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && res_q.kind == KIND_BEST && res_q.no_window)
			|-> (res_q.score == SCORE_MIN && !res_q.above_cutoff))
		else $error("short sequence result carries a score");

endmodule

// ===== rtl/motif_window_log_odds_scanner.sv =====
// Top level of the motif window log-odds scanner: ports, configuration and glue.
`timescale 1ns / 1ps

// The scanner takes one item per clock while the output is not stalled: table loads,
// k-mer codes and end-of-sequence markers all flow through the same pipeline, so a load
// is visible to every code that follows it. A code is reduced to its context row in three
// stages (byte fold, reciprocal multiply, back-multiply and subtract), the table row
// holding all motif columns is read from the table memory into a register, and the
// accumulate stage adds that row to every pending window sum at once. A result passes
// the row stages, the accumulate stage with the table read register, then the output register.
// The output register holds a result until it is taken; while it holds an untaken result,
// the accumulate stage, and behind it the input, stall. The table has no reset; every
// entry that is scanned must be loaded first.
module motif_window_log_odds_scanner import mwls_pkg::*; #(
	parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
	parameter int CONTEXT_ORDER = DEF_CONTEXT_ORDER,
	parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
	parameter int MAX_SEQ_LEN   = DEF_MAX_SEQ_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// kmer_code[31:0], table_row[37:32], table_column[42:38], table_value[58:43], zero pad
	input  logic [63:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// start_position[15:0], score[39:16], above_cutoff[40], no_window[41], zero pad
	output logic [47:0] m_axis_tdata,
	// kind[0]
	output logic [0:0]  m_axis_tuser,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [23:0] cfg_wdata
);

	localparam int NUM_ROWS = ALPHABET_SIZE ** (CONTEXT_ORDER + 1);
	localparam int RW = $clog2(NUM_ROWS);
	localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic signed [23:0] cutoff_q;
	logic [5:0] width_q;
	item_t in_item, row_item;
	logic row_valid, acc_ready, tbl_go, tbl_we;
	logic [RW-1:0] row_addr;
	logic [MAX_WIDTH-1:0][15:0] rd_data;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RESET;
			width_q  <= WIDTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CUTOFF:      cutoff_q <= cfg_wdata;
				REG_MOTIF_WIDTH: width_q  <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		in_item.func    = s_axis_tuser;
		in_item.load_ok = 1'b0;
		in_item.code    = s_axis_tdata[31:0];
		in_item.trow    = s_axis_tdata[37:32];
		in_item.tcol    = s_axis_tdata[42:38];
		in_item.tval    = s_axis_tdata[58:43];
	end

	mwls_rowmod #(
		.NUM_ROWS (NUM_ROWS),
		.MAX_WIDTH(MAX_WIDTH),
		.RW       (RW)
	) u_rowmod (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.out_valid(row_valid),
		.out_ready(acc_ready),
		.out_item (row_item),
		.out_row  (row_addr)
	);

	// The table is read for every item that moves into the accumulate stage; loads
	// write at that same point so that program order holds without forwarding.
	assign tbl_go = row_valid && acc_ready;
	assign tbl_we = tbl_go && (row_item.func == FUNC_LOAD) && row_item.load_ok;

	mwls_table #(
		.NUM_ROWS (NUM_ROWS),
		.MAX_WIDTH(MAX_WIDTH),
		.RW       (RW),
		.IW       (IW)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(row_addr),
		.wcol (IW'(row_item.tcol)),
		.wdata(row_item.tval),
		.re   (tbl_go),
		.raddr(row_addr),
		.rdata(rd_data)
	);

	mwls_accum #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_SEQ_LEN(MAX_SEQ_LEN)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (row_valid),
		.in_ready   (acc_ready),
		.in_item    (row_item),
		.rd_data    (rd_data),
		.cutoff     (cutoff_q),
		.motif_width(width_q),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (res)
	);

	assign m_axis_tdata = {6'd0, res.no_window, res.above_cutoff, res.score, res.start_position};
	assign m_axis_tuser = res.kind;

endmodule
